@@ rtl/daq_frame_decoder_histogrammer_top_assert.svh @@
// Assertion macros of the frame decoder and histogrammer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DAQ_FRAME_DECODER_HISTOGRAMMER_TOP_ASSERT_SVH
`define DAQ_FRAME_DECODER_HISTOGRAMMER_TOP_ASSERT_SVH

// A condition that must never hold at a clock edge outside reset.
`define DFDH_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define DFDH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define DFDH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dfdh_pkg.sv @@
// Package of the frame decoder and histogrammer: types, codes and constants.
// Depends on nothing; used by every module of the block.
`default_nettype none

package dfdh_pkg;

	localparam int CHANNELS_DEFAULT   = 64;
	localparam int BINS_DEFAULT       = 4096;
	localparam int COUNT_BITS_DEFAULT = 32;
	localparam int QUEUE_DEPTH        = 4;

	localparam logic [31:0] ADC_MASK   = 32'h0068_0000;
	localparam logic [31:0] ADC_HIGH   = 32'h0000_0000;
	localparam logic [31:0] ADC_LOW    = 32'h0008_0000;
	localparam logic [31:0] TDC_MASK   = 32'h0060_1000;
	localparam logic [31:0] TDC_LEAD   = 32'h0020_1000;
	localparam logic [31:0] TDC_TRAIL  = 32'h0020_0000;
	localparam logic [31:0] SCL_MASK   = 32'h0060_0000;
	localparam logic [31:0] SCL_MATCH  = 32'h0040_0000;
	localparam int          HEADER_BIT = 27;

	typedef enum logic [3:0] {
		KIND_HEADER,
		KIND_TIME,
		KIND_ADC_HIGH,
		KIND_ADC_LOW,
		KIND_TDC_LEAD,
		KIND_TDC_TRAIL,
		KIND_SCALER,
		KIND_UNKNOWN,
		KIND_FRAME_ERROR,
		KIND_READ
	} word_kind_t;

	typedef enum logic [1:0] {
		HOP_NONE,
		HOP_INC,
		HOP_READ
	} hist_op_t;

	typedef enum logic [1:0] {
		HIST_ADC_HIGH,
		HIST_ADC_LOW,
		HIST_TDC_LEAD,
		HIST_TDC_TRAIL
	} hist_kind_t;

	typedef struct packed {
		word_kind_t  word_kind;
		logic [6:0]  hit_channel;
		logic [13:0] hit_value;
		logic        out_of_range;
		logic [11:0] frame_length;
		logic [31:0] frame_time;
	} result_t;

	typedef struct packed {
		hist_op_t    op;
		hist_kind_t  kind;
		logic [5:0]  channel;
		logic [11:0] bin;
	} hist_cmd_t;

	typedef struct packed {
		result_t   res;
		hist_cmd_t cmd;
	} entry_t;

endpackage

`default_nettype wire

@@ rtl/dfdh_front.sv @@
// Front end: accepts stream words and read requests, tracks the frame and decodes words.
// Depends on dfdh_pkg; feeds dfdh_queue.
`default_nettype none

module dfdh_front #(
	parameter int CHANNELS = dfdh_pkg::CHANNELS_DEFAULT,
	parameter int BINS     = dfdh_pkg::BINS_DEFAULT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic            op,
	input  wire logic [31:0]     word,
	input  wire logic [1:0]      read_kind,
	input  wire logic [5:0]      read_channel,
	input  wire logic [11:0]     read_bin,
	input  wire logic            clearing,
	output logic                 push_valid,
	input  wire logic            push_ready,
	output dfdh_pkg::entry_t     push_entry
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_TIME,
		PH_DATA
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [11:0] words_left_q, words_left_d;
	logic [11:0] length_q, length_d;
	logic [31:0] time_q, time_d;
	logic        accept;
	logic        ch_ok, bin_ok, rd_ch_ok, rd_bin_ok;
	logic [11:0] words_dec;
	dfdh_pkg::entry_t ent;

	assign s_tready   = push_ready && !clearing;
	assign accept     = s_tvalid && s_tready;
	assign push_valid = accept;
	assign push_entry = ent;

	assign ch_ok     = {1'b0, word[18:13]} < 7'(CHANNELS);
	assign bin_ok    = {1'b0, word[11:0]} < 13'(BINS);
	assign rd_ch_ok  = {1'b0, read_channel} < 7'(CHANNELS);
	assign rd_bin_ok = {1'b0, read_bin} < 13'(BINS);
	assign words_dec = words_left_q - 12'd1;

	always_comb begin
		phase_d      = phase_q;
		words_left_d = words_left_q;
		length_d     = length_q;
		time_d       = time_q;
		ent          = '0;
		ent.cmd.op   = dfdh_pkg::HOP_NONE;
		if (op) begin
			ent.res.word_kind = dfdh_pkg::KIND_READ;
			ent.cmd.kind      = dfdh_pkg::hist_kind_t'(read_kind);
			ent.cmd.channel   = read_channel;
			ent.cmd.bin       = read_bin;
			if (rd_ch_ok && rd_bin_ok) begin
				ent.cmd.op = dfdh_pkg::HOP_READ;
			end
		end else begin
			unique case (phase_q)
				PH_TIME: begin
					ent.res.word_kind = dfdh_pkg::KIND_TIME;
					time_d            = word;
					words_left_d      = length_q;
					phase_d           = (length_q != 12'd0) ? PH_DATA : PH_HEADER;
				end
				PH_DATA: begin
					ent.cmd.channel = word[18:13];
					ent.cmd.bin     = word[11:0];
					priority if ((word & dfdh_pkg::ADC_MASK) == dfdh_pkg::ADC_HIGH ||
							(word & dfdh_pkg::ADC_MASK) == dfdh_pkg::ADC_LOW) begin
						if ((word & dfdh_pkg::ADC_MASK) == dfdh_pkg::ADC_HIGH) begin
							ent.res.word_kind = dfdh_pkg::KIND_ADC_HIGH;
							ent.cmd.kind      = dfdh_pkg::HIST_ADC_HIGH;
						end else begin
							ent.res.word_kind = dfdh_pkg::KIND_ADC_LOW;
							ent.cmd.kind      = dfdh_pkg::HIST_ADC_LOW;
						end
						ent.res.hit_channel  = {1'b0, word[18:13]};
						ent.res.hit_value    = {2'b00, word[11:0]};
						ent.res.out_of_range = word[12];
						if (!word[12] && ch_ok && bin_ok) begin
							ent.cmd.op = dfdh_pkg::HOP_INC;
						end
					end else if ((word & dfdh_pkg::TDC_MASK) == dfdh_pkg::TDC_LEAD ||
							(word & dfdh_pkg::TDC_MASK) == dfdh_pkg::TDC_TRAIL) begin
						if ((word & dfdh_pkg::TDC_MASK) == dfdh_pkg::TDC_LEAD) begin
							ent.res.word_kind = dfdh_pkg::KIND_TDC_LEAD;
							ent.cmd.kind      = dfdh_pkg::HIST_TDC_LEAD;
						end else begin
							ent.res.word_kind = dfdh_pkg::KIND_TDC_TRAIL;
							ent.cmd.kind      = dfdh_pkg::HIST_TDC_TRAIL;
						end
						ent.res.hit_channel = {1'b0, word[18:13]};
						ent.res.hit_value   = {2'b00, word[11:0]};
						if (ch_ok && bin_ok) begin
							ent.cmd.op = dfdh_pkg::HOP_INC;
						end
					end else if ((word & dfdh_pkg::SCL_MASK) == dfdh_pkg::SCL_MATCH) begin
						ent.res.word_kind   = dfdh_pkg::KIND_SCALER;
						ent.res.hit_channel = word[20:14];
						ent.res.hit_value   = word[13:0];
					end else begin
						ent.res.word_kind = dfdh_pkg::KIND_UNKNOWN;
					end
					words_left_d = words_dec;
					if (words_dec == 12'd0) begin
						phase_d = PH_HEADER;
					end
				end
				PH_HEADER: begin
					if (word[dfdh_pkg::HEADER_BIT]) begin
						ent.res.word_kind = dfdh_pkg::KIND_HEADER;
						length_d          = word[11:0];
						time_d            = '0;
						phase_d           = PH_TIME;
					end else begin
						ent.res.word_kind = dfdh_pkg::KIND_FRAME_ERROR;
					end
				end
				default: begin
					ent.res.word_kind = dfdh_pkg::KIND_FRAME_ERROR;
					phase_d           = PH_HEADER;
				end
			endcase
			ent.res.frame_length = length_d;
			ent.res.frame_time   = time_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			words_left_q <= '0;
			length_q     <= '0;
			time_q       <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			words_left_q <= words_left_d;
			length_q     <= length_d;
			time_q       <= time_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/dfdh_queue.sv @@
// Short queue of decoded entries between the front end and the histogram back end.
// Depends on dfdh_pkg for the entry type and depth.
`default_nettype none

module dfdh_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire dfdh_pkg::entry_t push_entry,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output dfdh_pkg::entry_t      pop_entry
);

	localparam int AW = $clog2(dfdh_pkg::QUEUE_DEPTH);

	dfdh_pkg::entry_t slots_q [dfdh_pkg::QUEUE_DEPTH];
	logic [AW:0]      wr_ptr_q, rd_ptr_q;
	logic             full, empty, do_push, do_pop;

	assign empty      = wr_ptr_q == rd_ptr_q;
	assign full       = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop_entry  = slots_q[rd_ptr_q[AW-1:0]];
	assign do_push    = push_valid && !full;
	assign do_pop     = pop_ready && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q[AW-1:0]] <= push_entry;
		end
	end

endmodule

`default_nettype wire

@@ rtl/dfdh_back.sv @@
// Back end: bin counter memory with read-modify-write, read-back and the output register.
// Depends on dfdh_pkg and the assertion macro header; fed by dfdh_queue.
`default_nettype none
`include "daq_frame_decoder_histogrammer_top_assert.svh"

module dfdh_back #(
	parameter int CHANNELS   = dfdh_pkg::CHANNELS_DEFAULT,
	parameter int BINS       = dfdh_pkg::BINS_DEFAULT,
	parameter int COUNT_BITS = dfdh_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	output logic                  q_ready,
	input  wire dfdh_pkg::entry_t q_entry,
	output logic                  clearing,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output dfdh_pkg::result_t     m_res,
	output logic [31:0]           m_count
);

	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int BIN_W     = $clog2(BINS);
	localparam int MEM_AW    = 2 + CH_W + BIN_W;
	localparam int MEM_DEPTH = 1 << MEM_AW;

	logic [COUNT_BITS-1:0] mem [MEM_DEPTH];

	logic                  clearing_q;
	logic [MEM_AW-1:0]     clr_addr_q;
	logic                  valid_s1;
	dfdh_pkg::entry_t      entry_s1;
	logic [MEM_AW-1:0]     addr_s1;
	logic [COUNT_BITS-1:0] rd_data_s1;
	logic                  fwd_valid_q;
	logic [MEM_AW-1:0]     fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;
	logic                  out_valid_q;
	dfdh_pkg::result_t     out_res_q;
	logic [31:0]           out_count_q;

	logic [MEM_AW-1:0]     pop_addr;
	logic                  pop, s1_move, wr_en;
	logic [COUNT_BITS-1:0] cur, inc_data;
	logic [31:0]           cnt32;

	assign pop_addr = {q_entry.cmd.kind, q_entry.cmd.channel[CH_W-1:0],
		q_entry.cmd.bin[BIN_W-1:0]};
	assign s1_move  = valid_s1 && (!out_valid_q || m_tready);
	assign pop      = q_valid && !clearing_q && (!valid_s1 || s1_move);
	assign q_ready  = pop;
	assign clearing = clearing_q;

	assign cur      = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data_s1;
	assign inc_data = (&cur) ? cur : cur + {{(COUNT_BITS-1){1'b0}}, 1'b1};
	assign wr_en    = s1_move && entry_s1.cmd.op == dfdh_pkg::HOP_INC;

	generate
		if (COUNT_BITS > 32) begin : g_sat
			assign cnt32 = (|cur[COUNT_BITS-1:32]) ? '1 : cur[31:0];
		end else begin : g_ext
			assign cnt32 = 32'(cur);
		end
	endgenerate

	assign m_tvalid = out_valid_q;
	assign m_res    = out_res_q;
	assign m_count  = out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q) begin
					clearing_q <= 1'b0;
				end
			end
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en) begin
				fwd_valid_q <= 1'b1;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[addr_s1] <= inc_data;
		end
		if (pop) begin
			rd_data_s1 <= mem[pop_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_s1 <= q_entry;
			addr_s1  <= pop_addr;
		end
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= inc_data;
		end
		if (s1_move) begin
			out_res_q   <= entry_s1.res;
			out_count_q <= (entry_s1.cmd.op == dfdh_pkg::HOP_READ) ? cnt32 : 32'd0;
		end
	end

	`DFDH_ASSERT_NEVER(a_no_pop_while_clearing, clk, arst_n, clearing_q && pop, "Entry taken during the clearing pass.")
	`DFDH_ASSERT_IMP(a_inc_nonzero, clk, arst_n, wr_en, inc_data != '0, "Incremented counter wrote zero.")
	`DFDH_ASSERT_IMP(a_count_only_on_read, clk, arst_n, out_valid_q && out_res_q.word_kind != dfdh_pkg::KIND_READ, out_count_q == 32'd0, "Counter value on a stream result.")
	`DFDH_ASSERT_NEXT(a_pop_fills_s1, clk, arst_n, pop, valid_s1, "Popped entry did not reach the first stage.")

endmodule

`default_nettype wire

@@ rtl/daq_frame_decoder_histogrammer_top.sv @@
// Top level of the readout frame decoder and online histogrammer.
// Depends on dfdh_pkg, dfdh_front, dfdh_queue and dfdh_back.
`default_nettype none

// The block takes one item per clock when m_tready is held high and no clearing pass runs,
// and returns one result per item, in order. A stream word is decoded against the frame
// (header, time word, data words); TDC hits, and ADC hits without the out-of-range flag, that
// fall within CHANNELS and BINS add one to a saturating bin counter chosen by kind, channel
// and value; a read returns one counter. A result passes through the queue, the counter stage
// and the output register, where one read-modify-write of the single-write-port counter
// memory per cycle, with forwarding of the last write, sets the rate of one item per clock.
// After reset the counter memory is cleared one entry per cycle; s_tready stays low until
// it is done.
module daq_frame_decoder_histogrammer_top #(
	parameter int CHANNELS   = dfdh_pkg::CHANNELS_DEFAULT,
	parameter int BINS       = dfdh_pkg::BINS_DEFAULT,
	parameter int COUNT_BITS = dfdh_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// word [31:0], read_kind [33:32], read_channel [39:34], read_bin [51:40], zero pad.
	input  wire logic [55:0]  s_tdata,
	// op.
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// hit_channel [6:0], hit_value [20:7], out_of_range [21], frame_length [33:22],
	// frame_time [65:34], bin_count [97:66], zero pad.
	output logic [103:0]      m_tdata,
	// word_kind.
	output logic [3:0]        m_tuser
);

	logic              push_valid, push_ready, pop_valid, pop_ready, clearing;
	dfdh_pkg::entry_t  push_entry, pop_entry;
	dfdh_pkg::result_t res;
	logic [31:0]       count;

	dfdh_front #(
		.CHANNELS (CHANNELS),
		.BINS     (BINS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.op           (s_tuser),
		.word         (s_tdata[31:0]),
		.read_kind    (s_tdata[33:32]),
		.read_channel (s_tdata[39:34]),
		.read_bin     (s_tdata[51:40]),
		.clearing     (clearing),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_entry   (push_entry)
	);

	dfdh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	dfdh_back #(
		.CHANNELS   (CHANNELS),
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (pop_valid),
		.q_ready  (pop_ready),
		.q_entry  (pop_entry),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_res    (res),
		.m_count  (count)
	);

	assign m_tuser = res.word_kind;
	assign m_tdata = {6'b0, count, res.frame_time, res.frame_length, res.out_of_range,
		res.hit_value, res.hit_channel};

endmodule

`default_nettype wire

@@ verif/tb_daq_frame_decoder_histogrammer_top.sv @@
// Self-checking testbench of daq_frame_decoder_histogrammer_top: directed and random readout
// frames and bin reads, each result checked against a frame decoder and bin counter model.
// Depends on dfdh_pkg and the block's RTL.
module tb_daq_frame_decoder_histogrammer_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_STREAM = 1'b0;
	localparam logic OP_READ   = 1'b1;
	localparam logic [31:0] TALLY_MAX = 32'hffff_ffff;

	typedef enum logic [1:0] {
		AWAIT_HEADER,
		AWAIT_TIME,
		IN_DATA
	} frame_state_t;

	typedef struct {
		logic                 op;
		logic [31:0]          word;
		dfdh_pkg::hist_kind_t rkind;
		logic [5:0]           rch;
		logic [11:0]          rbin;
	} stim_t;

	typedef struct {
		dfdh_pkg::word_kind_t kind;
		logic [6:0]           ch;
		logic [13:0]          val;
		logic                 otr;
		logic [11:0]          flen;
		logic [31:0]          ftime;
		logic [31:0]          cnt;
	} outcome_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [55:0]  s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [3:0]   m_tuser;

	stim_t        feed_q[$];
	outcome_t     pending_results[$];
	logic [31:0]  bin_tally[logic [19:0]];
	frame_state_t frame_state = AWAIT_HEADER;
	logic [11:0]  words_left = '0;
	logic [11:0]  length_hold = '0;
	logic [31:0]  time_hold = '0;
	logic [5:0]   hot_ch[4];
	logic [11:0]  hot_val[4];
	bit           in_taken = 1'b0;
	int           taken_count = 0;
	int           total_items = 0;
	int           bound_a = 0;
	int           bound_b = 0;
	int           fail_count = 0;

	daq_frame_decoder_histogrammer_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	function automatic void tally_hit(dfdh_pkg::hist_kind_t hk, logic [5:0] ch, logic [11:0] v);
		logic [19:0] key;
		key = {hk, ch, v};
		if (!bin_tally.exists(key))
			bin_tally[key] = 32'd1;
		else if (bin_tally[key] != TALLY_MAX)
			bin_tally[key] = bin_tally[key] + 32'd1;
	endfunction

	function automatic outcome_t decode_and_count(stim_t it);
		outcome_t    r;
		logic [31:0] w;
		logic [19:0] key;
		w = it.word;
		r.kind = dfdh_pkg::KIND_READ;
		r.ch = '0;
		r.val = '0;
		r.otr = 1'b0;
		r.flen = '0;
		r.ftime = '0;
		r.cnt = '0;
		if (it.op == OP_READ) begin
			key = {it.rkind, it.rch, it.rbin};
			if (bin_tally.exists(key))
				r.cnt = bin_tally[key];
			return r;
		end
		case (frame_state)
			AWAIT_TIME: begin
				r.kind = dfdh_pkg::KIND_TIME;
				time_hold = w;
				words_left = length_hold;
				frame_state = (length_hold != 0) ? IN_DATA : AWAIT_HEADER;
			end
			IN_DATA: begin
				if ((w & dfdh_pkg::ADC_MASK) == dfdh_pkg::ADC_HIGH ||
						(w & dfdh_pkg::ADC_MASK) == dfdh_pkg::ADC_LOW) begin
					if ((w & dfdh_pkg::ADC_MASK) == dfdh_pkg::ADC_HIGH)
						r.kind = dfdh_pkg::KIND_ADC_HIGH;
					else
						r.kind = dfdh_pkg::KIND_ADC_LOW;
					r.ch = {1'b0, w[18:13]};
					r.otr = w[12];
					r.val = {2'b00, w[11:0]};
					if (!w[12]) begin
						if (r.kind == dfdh_pkg::KIND_ADC_HIGH)
							tally_hit(dfdh_pkg::HIST_ADC_HIGH, w[18:13], w[11:0]);
						else
							tally_hit(dfdh_pkg::HIST_ADC_LOW, w[18:13], w[11:0]);
					end
				end else if ((w & dfdh_pkg::TDC_MASK) == dfdh_pkg::TDC_LEAD ||
						(w & dfdh_pkg::TDC_MASK) == dfdh_pkg::TDC_TRAIL) begin
					r.ch = {1'b0, w[18:13]};
					r.val = {2'b00, w[11:0]};
					if ((w & dfdh_pkg::TDC_MASK) == dfdh_pkg::TDC_LEAD) begin
						r.kind = dfdh_pkg::KIND_TDC_LEAD;
						tally_hit(dfdh_pkg::HIST_TDC_LEAD, w[18:13], w[11:0]);
					end else begin
						r.kind = dfdh_pkg::KIND_TDC_TRAIL;
						tally_hit(dfdh_pkg::HIST_TDC_TRAIL, w[18:13], w[11:0]);
					end
				end else if ((w & dfdh_pkg::SCL_MASK) == dfdh_pkg::SCL_MATCH) begin
					r.kind = dfdh_pkg::KIND_SCALER;
					r.ch = w[20:14];
					r.val = w[13:0];
				end else begin
					r.kind = dfdh_pkg::KIND_UNKNOWN;
				end
				words_left = words_left - 12'd1;
				if (words_left == 0)
					frame_state = AWAIT_HEADER;
			end
			default: begin
				frame_state = AWAIT_HEADER;
				if (w[dfdh_pkg::HEADER_BIT]) begin
					r.kind = dfdh_pkg::KIND_HEADER;
					length_hold = w[11:0];
					time_hold = '0;
					frame_state = AWAIT_TIME;
				end else begin
					r.kind = dfdh_pkg::KIND_FRAME_ERROR;
				end
			end
		endcase
		r.flen = length_hold;
		r.ftime = time_hold;
		return r;
	endfunction

	function automatic void push_word(logic [31:0] w);
		stim_t s;
		s.op = OP_STREAM;
		s.word = w;
		s.rkind = dfdh_pkg::hist_kind_t'($urandom_range(0, 3));
		s.rch = 6'($urandom);
		s.rbin = 12'($urandom);
		feed_q.push_back(s);
	endfunction

	function automatic void push_read(dfdh_pkg::hist_kind_t hk, logic [5:0] ch, logic [11:0] v);
		stim_t s;
		s.op = OP_READ;
		s.word = $urandom;
		s.rkind = hk;
		s.rch = ch;
		s.rbin = v;
		feed_q.push_back(s);
	endfunction

	function automatic void push_random_read();
		logic [5:0]  ch;
		logic [11:0] v;
		ch = ($urandom_range(0, 3) != 0) ? hot_ch[$urandom_range(0, 3)] : 6'($urandom);
		v = ($urandom_range(0, 3) != 0) ? hot_val[$urandom_range(0, 3)] : 12'($urandom);
		push_read(dfdh_pkg::hist_kind_t'($urandom_range(0, 3)), ch, v);
	endfunction

	function automatic logic [31:0] make_data_word();
		logic [31:0] w;
		w = $urandom;
		w[18:13] = ($urandom_range(0, 2) != 0) ? hot_ch[$urandom_range(0, 3)] : 6'($urandom);
		w[11:0] = ($urandom_range(0, 2) != 0) ? hot_val[$urandom_range(0, 3)] : 12'($urandom);
		case ($urandom_range(0, 10))
			0, 1: begin
				w[22:21] = 2'b00;
				w[19] = 1'b0;
				w[12] = ($urandom_range(0, 5) == 0);
			end
			2, 3: begin
				w[22:21] = 2'b00;
				w[19] = 1'b1;
				w[12] = ($urandom_range(0, 5) == 0);
			end
			4, 5: begin
				w[22:21] = 2'b01;
				w[12] = 1'b1;
			end
			6, 7: begin
				w[22:21] = 2'b01;
				w[12] = 1'b0;
			end
			8: w[22:21] = 2'b10;
			9: w[22:21] = 2'b11;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic void push_frame(int len, bit truncate);
		logic [31:0] hdr;
		int          n;
		hdr = $urandom;
		hdr[dfdh_pkg::HEADER_BIT] = 1'b1;
		hdr[11:0] = 12'(len);
		push_word(hdr);
		push_word($urandom);
		n = (truncate && len > 0) ? $urandom_range(0, len - 1) : len;
		repeat (n) push_word(make_data_word());
	endfunction

	function automatic void fill_random(int goal);
		int roll;
		int len;
		while (feed_q.size() < goal) begin
			roll = $urandom_range(0, 99);
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 200) : $urandom_range(0, 12);
			if (roll < 68)
				push_frame(len, 1'b0);
			else if (roll < 76)
				push_frame(len, 1'b1);
			else if (roll < 83)
				push_word($urandom);
			else
				push_random_read();
		end
	endfunction

	function automatic int sender_idle_pct();
		if (taken_count < bound_a)
			return 12;
		else if (taken_count < bound_b)
			return 46;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (taken_count < bound_a)
			return 46;
		else if (taken_count < bound_b)
			return 12;
		return 0;
	endfunction

	function automatic void check_transfer(outcome_t e);
		if (m_tuser != e.kind) begin
			$error("word_kind: expected %0d, got %0d", e.kind, m_tuser);
			fail_count++;
		end
		if (m_tdata[6:0] != e.ch) begin
			$error("hit_channel: expected %0d, got %0d", e.ch, m_tdata[6:0]);
			fail_count++;
		end
		if (m_tdata[20:7] != e.val) begin
			$error("hit_value: expected %0d, got %0d", e.val, m_tdata[20:7]);
			fail_count++;
		end
		if (m_tdata[21] != e.otr) begin
			$error("out_of_range: expected %0d, got %0d", e.otr, m_tdata[21]);
			fail_count++;
		end
		if (m_tdata[33:22] != e.flen) begin
			$error("frame_length: expected %0d, got %0d", e.flen, m_tdata[33:22]);
			fail_count++;
		end
		if (m_tdata[65:34] != e.ftime) begin
			$error("frame_time: expected 0x%08h, got 0x%08h", e.ftime, m_tdata[65:34]);
			fail_count++;
		end
		if (m_tdata[97:66] != e.cnt) begin
			$error("bin_count: expected %0d, got %0d", e.cnt, m_tdata[97:66]);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : watch
		stim_t taken;
		if (arst_n) begin
			in_taken = s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with kind %0d arrived with nothing expected", m_tuser);
					fail_count++;
				end else begin
					check_transfer(pending_results.pop_front());
				end
			end
			if (in_taken) begin
				taken.op = s_tuser;
				taken.word = s_tdata[31:0];
				taken.rkind = dfdh_pkg::hist_kind_t'(s_tdata[33:32]);
				taken.rch = s_tdata[39:34];
				taken.rbin = s_tdata[51:40];
				pending_results.push_back(decode_and_count(taken));
				taken_count++;
			end
		end
	end

	always @(negedge clk) begin : feed
		stim_t cur;
		logic  nxt_valid;
		if (arst_n) begin
			nxt_valid = s_tvalid && !in_taken;
			if (!nxt_valid && feed_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
				cur = feed_q.pop_front();
				s_tdata <= {4'h0, cur.rbin, cur.rch, cur.rkind, cur.word};
				s_tuser <= cur.op;
				nxt_valid = 1'b1;
			end
			s_tvalid <= nxt_valid;
			m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
		end
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		hot_ch[0] = 6'd0;
		hot_ch[1] = 6'd63;
		hot_ch[2] = 6'($urandom);
		hot_ch[3] = 6'($urandom);
		hot_val[0] = 12'd0;
		hot_val[1] = 12'hfff;
		hot_val[2] = 12'($urandom);
		hot_val[3] = 12'($urandom);

		push_read(dfdh_pkg::HIST_ADC_HIGH, 6'd0, 12'd0);
		push_word(32'h0000_0000);
		push_word(32'hf7ff_ffff);
		push_word(32'h0800_0000);
		push_word(32'hffff_ffff);
		push_word(32'h0800_0008);
		push_word(32'h1234_5678);
		push_word(32'h0007_efff);
		push_word(32'h0008_0000);
		push_word(32'h0000_1abc);
		push_word(32'h0020_1000 | (32'd5 << 13) | 32'h123);
		push_word(32'h0027_efff);
		push_word(32'h005f_ffff);
		push_word(32'hffff_ffff);
		push_word(32'h0060_0000);
		push_read(dfdh_pkg::HIST_ADC_HIGH, 6'd63, 12'hfff);
		push_read(dfdh_pkg::HIST_ADC_LOW, 6'd0, 12'd0);
		push_read(dfdh_pkg::HIST_ADC_HIGH, 6'd0, 12'habc);
		push_read(dfdh_pkg::HIST_TDC_LEAD, 6'd5, 12'h123);
		push_read(dfdh_pkg::HIST_TDC_TRAIL, 6'd63, 12'hfff);

		fill_random(250);
		bound_a = feed_q.size();
		fill_random(500);
		bound_b = feed_q.size();
		push_frame(700, 1'b0);
		fill_random(feed_q.size() + 500);
		total_items = feed_q.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (taken_count == total_items);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dfdh_pkg.sv
rtl/dfdh_front.sv
rtl/dfdh_queue.sv
rtl/dfdh_back.sv
rtl/daq_frame_decoder_histogrammer_top.sv
verif/tb_daq_frame_decoder_histogrammer_top.sv
